@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define PXFR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PXFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/pxfr_pkg.sv @@
`timescale 1ns / 1ps

package pxfr_pkg;

  localparam int MAX_WORDS = 32;
  localparam int ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CNT_MAX   = MAX_WORDS + 2;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);

  localparam int FL_W     = 6;
  localparam int BYTE_W   = 8;
  localparam int WIDX_W   = 5;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = ((CNT_W > FL_W) ? CNT_W : FL_W) + 1;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_AW      = 3;
  localparam int CFG_DW      = 32;
  localparam int REG_IDX_W   = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_LENGTH = '0;

  localparam logic [BYTE_W-1:0] OFFSET     = 8'h20;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'd10;
  localparam logic [FL_W-1:0]   FL_RESET   = 6'd8;

  typedef logic [STATUS_W-1:0] status_t;
  localparam status_t ST_GOOD   = 2'd0;
  localparam status_t ST_CHECK  = 2'd1;
  localparam status_t ST_LENGTH = 2'd2;

  typedef struct packed {
    logic take_byte;
    logic close_frame;
    logic load_err;
    logic clr_idx;
    logic ren;
    logic load_good;
    logic inc_idx;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_nl;
    logic len_bad;
    logic chk_bad;
    logic last_word;
    logic out_free;
  } dp_sts_t;

endpackage

@@ sv/printable_xor_frame_receiver_top.sv @@
`timescale 1ns / 1ps

// Frame receiver for a printable serial link. Each accepted byte other than a newline is
// shifted down by 0x20 and stored at the next frame position; the byte after frame_length
// data words is the checksum. A newline closes the frame: a frame of exactly frame_length
// words plus a checksum equal to the XOR of the words yields one result transaction per
// word (index in tdata, last word flagged by tlast), and any other frame yields a single
// error transaction (wrong length before checksum mismatch). An ordinary byte is taken
// without a stall, and so is a newline with an error, which leaves one result. A good
// frame stalls the input while each word is read from the word RAM in the fetch state
// and moved to the output register in the send state; backpressure on the output adds
// to that. The input is also held off while a last result still waits in the output
// register. frame_length sits at byte address 0 of the register port and resets to 8.

module printable_xor_frame_receiver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // tdata: [7:0] rx_byte
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pxfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tdata: [4:0] word_index, [12:5] data_word, [15:13] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pxfr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // tuser: [1:0] status
  output logic [pxfr_pkg::STATUS_W-1:0]       out_tuser,
  output logic                                out_tlast,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [pxfr_pkg::CFG_AW-1:0]         cfg_paddr,
  input  logic [pxfr_pkg::CFG_DW-1:0]         cfg_pwdata,
  output logic [pxfr_pkg::CFG_DW-1:0]         cfg_prdata,
  output logic                                cfg_pready
);
  import pxfr_pkg::*;

  logic [FL_W-1:0] frame_length_r, frame_length_nxt;
  logic            sel_fl;
  ctl_cmd_t        cmd;
  dp_sts_t         sts;

  assign cfg_pready = 1'b1;
  assign sel_fl     = (cfg_paddr[CFG_AW-1:2] == REG_FRAME_LENGTH);

  always_comb begin
    frame_length_nxt = frame_length_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && sel_fl) begin
      frame_length_nxt = cfg_pwdata[FL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FL_RESET;
    end else begin
      frame_length_r <= frame_length_nxt;
    end
  end

  assign cfg_prdata = sel_fl ? CFG_DW'(frame_length_r) : '0;

  pxfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pxfr_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_length (frame_length_r),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

@@ sv/pxfr_ram.sv @@
`timescale 1ns / 1ps

module pxfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/pxfr_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pxfr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  pxfr_pkg::dp_sts_t  sts,
  output pxfr_pkg::ctl_cmd_t cmd
);
  import pxfr_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_SEND} state_t;

  state_t state_r, state_nxt;
  logic   acc;

  assign in_tready = (state_r == S_IDLE) && sts.out_free;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        cmd.take_byte   = acc && !sts.is_nl;
        cmd.close_frame = acc && sts.is_nl;
        if (acc && sts.is_nl) begin
          if (sts.len_bad || sts.chk_bad) begin
            cmd.load_err = 1'b1;
          end else begin
            cmd.clr_idx = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        cmd.ren   = 1'b1;
        state_nxt = S_SEND;
      end
      S_SEND: begin
        // The RAM output holds until the output register has room.
        if (sts.out_free) begin
          cmd.load_good = 1'b1;
          if (sts.last_word) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.inc_idx = 1'b1;
            state_nxt   = S_FETCH;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `PXFR_ASSERT(a_good_frame_fetch, clk, rst_n, cmd.clr_idx |=> (state_r == S_FETCH), "good frame did not start a fetch")
  `PXFR_ASSERT(a_last_word_idle, clk, rst_n, (cmd.load_good && sts.last_word) |=> (state_r == S_IDLE), "last word did not return to idle")
  `PXFR_ASSERT(a_no_input_in_burst, clk, rst_n, (state_r != S_IDLE) |=> !(cmd.take_byte || cmd.close_frame) || ($past(state_r) == S_SEND), "byte taken during burst")

endmodule

@@ sv/pxfr_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pxfr_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [pxfr_pkg::FL_W-1:0]           frame_length,
  input  logic [pxfr_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pxfr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic [pxfr_pkg::STATUS_W-1:0]       out_tuser,
  output logic                                out_tlast,
  input  pxfr_pkg::ctl_cmd_t                  cmd,
  output pxfr_pkg::dp_sts_t                   sts
);
  import pxfr_pkg::*;

  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  logic [BYTE_W-1:0] check_r, check_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [WIDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic [BYTE_W-1:0]   out_data_r, out_data_nxt;
  logic                out_last_r, out_last_nxt;

  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] word_val;
  logic              store_en;
  logic [BYTE_W-1:0] ram_rdata;

  assign rx_byte  = in_tdata[BYTE_W-1:0];
  assign word_val = rx_byte - OFFSET;
  assign store_en = cmd.take_byte && (cnt_r < CNT_W'(frame_length)) &&
                    (cnt_r < CNT_W'(MAX_WORDS));

  pxfr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MAX_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (store_en),
    .waddr (cnt_r[ADDR_W-1:0]),
    .wdata (word_val),
    .re    (cmd.ren),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    sts.is_nl   = (rx_byte == TERMINATOR);
    sts.len_bad = (frame_length == '0) || (frame_length > FL_W'(MAX_WORDS)) ||
                  (CMP_W'(cnt_r) != CMP_W'(frame_length) + CMP_W'(1));
    sts.chk_bad = (xor_r != check_r);
    sts.last_word = (CMP_W'(idx_r) + CMP_W'(1)) == CMP_W'(frame_length);
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_comb begin
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    check_nxt = check_r;
    if (cmd.take_byte) begin
      if (store_en) begin
        xor_nxt = xor_r ^ word_val;
      end else if (CMP_W'(cnt_r) == CMP_W'(frame_length)) begin
        check_nxt = word_val;
      end
      if (cnt_r < CNT_W'(CNT_MAX)) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
    if (cmd.close_frame) begin
      cnt_nxt   = '0;
      xor_nxt   = '0;
      check_nxt = '0;
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (cmd.clr_idx) begin
      idx_nxt = '0;
    end else if (cmd.inc_idx) begin
      idx_nxt = idx_r + ADDR_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    if (cmd.load_err) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = sts.len_bad ? ST_LENGTH : ST_CHECK;
      out_idx_nxt    = '0;
      out_data_nxt   = '0;
      out_last_nxt   = 1'b1;
    end else if (cmd.load_good) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = ST_GOOD;
      out_idx_nxt    = WIDX_W'(idx_r);
      out_data_nxt   = ram_rdata;
      out_last_nxt   = sts.last_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      xor_r       <= '0;
      check_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      check_r     <= check_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_TDATA_W'({out_data_r, out_idx_r});

  `PXFR_ASSERT(a_count_steps, clk, rst_n, (cmd.take_byte && (cnt_r < CNT_W'(CNT_MAX))) |=> (cnt_r == $past(cnt_r) + CNT_W'(1)), "byte count did not advance")
  `PXFR_ASSERT(a_frame_restart, clk, rst_n, cmd.close_frame |=> ((cnt_r == '0) && (xor_r == '0) && (check_r == '0)), "newline did not restart the frame")
  `PXFR_ASSERT(a_error_is_last, clk, rst_n, cmd.load_err |=> (out_tvalid && out_tlast && (out_tuser != ST_GOOD)), "error result malformed")

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pxfr_pkg::*;

  localparam int SETTLE_CYCLES = 2 * MAX_WORDS + 40;

  typedef struct packed {
    status_t                   status;
    logic [WIDX_W-1:0]         index;
    logic [BYTE_W-1:0]         word;
    logic                      is_last;
  } frame_result_t;

  typedef enum int {CHK_RIGHT, CHK_WRONG, CHK_NONE} chk_kind_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic [STATUS_W-1:0]     out_tuser;
  logic                    out_tlast;
  logic                    cfg_psel;
  logic                    cfg_penable;
  logic                    cfg_pwrite;
  logic [CFG_AW-1:0]       cfg_paddr;
  logic [CFG_DW-1:0]       cfg_pwdata;
  logic [CFG_DW-1:0]       cfg_prdata;
  logic                    cfg_pready;

  // Shadow of the receiver state, kept in step with accepted bytes.
  logic [BYTE_W-1:0] word_mem [MAX_WORDS];
  logic [BYTE_W-1:0] xor_acc = '0;
  logic [BYTE_W-1:0] chk_byte = '0;
  int                nbytes = 0;
  int                fl_shadow = int'(FL_RESET);

  frame_result_t     frame_results [$];
  int                err_count = 0;
  int                burst_left = 0;
  int                sent_count = 0;
  bit                hold_req = 1'b0;
  int                hold_len = 0;

  printable_xor_frame_receiver_top u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void push_result(status_t st, int idx, logic [BYTE_W-1:0] w, logic lst);
    frame_result_t r;
    r.status  = st;
    r.index   = idx[WIDX_W-1:0];
    r.word    = w;
    r.is_last = lst;
    frame_results.push_back(r);
  endfunction

  // Updates the shadow state for one accepted byte and queues the results it causes.
  function automatic void absorb_byte(logic [BYTE_W-1:0] rx);
    logic [BYTE_W-1:0] v;
    int i;
    if (rx != TERMINATOR) begin
      v = rx - OFFSET;
      if (nbytes < fl_shadow && nbytes < MAX_WORDS) begin
        word_mem[nbytes[ADDR_W-1:0]] = v;
        xor_acc ^= v;
      end else if (nbytes == fl_shadow) begin
        chk_byte = v;
      end
      if (nbytes < CNT_MAX) nbytes++;
    end else begin
      if (fl_shadow == 0 || fl_shadow > MAX_WORDS || nbytes != fl_shadow + 1) begin
        push_result(ST_LENGTH, 0, '0, 1'b1);
      end else if (xor_acc != chk_byte) begin
        push_result(ST_CHECK, 0, '0, 1'b1);
      end else begin
        for (i = 0; i < fl_shadow; i++) begin
          push_result(ST_GOOD, i, word_mem[i[ADDR_W-1:0]], i == fl_shadow - 1);
        end
      end
      nbytes   = 0;
      xor_acc  = '0;
      chk_byte = '0;
    end
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (frame_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d index %0d word %0d",
                 $time, out_tuser, out_tdata[4:0], out_tdata[12:5]);
        err_count++;
      end else begin
        want = frame_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_tuser));
        check_field("word_index", 32'(want.index), 32'(out_tdata[4:0]));
        check_field("data_word", 32'(want.word), 32'(out_tdata[12:5]));
        check_field("last", 32'(want.is_last), 32'(out_tlast));
      end
    end
  end

  // The result side stalls in stretches of changing density, or holds off entirely on request.
  initial begin
    int mode;
    int span;
    mode = 0;
    span = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 80);
        end
        span--;
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 1) == 1);
          2: out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] any_char();
    logic [BYTE_W-1:0] b;
    do b = BYTE_W'($urandom_range(0, 255)); while (b == TERMINATOR);
    return b;
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_byte(b);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(TERMINATOR);
  endtask

  // Random data words, then a right, wrong or missing checksum, then the newline.
  task automatic send_frame(input int n_words, input chk_kind_t chk);
    logic [BYTE_W-1:0] raw [$];
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] tail;
    int i;
    do begin
      raw.delete();
      sum = '0;
      for (i = 0; i < n_words; i++) begin
        raw.push_back(any_char());
        sum ^= raw[i] - OFFSET;
      end
      tail = sum + OFFSET;
      if (chk == CHK_WRONG) begin
        do tail = any_char(); while (tail == sum + OFFSET);
      end
    end while (chk == CHK_RIGHT && tail == TERMINATOR);
    foreach (raw[i]) send_byte(raw[i]);
    if (chk != CHK_NONE) send_byte(tail);
    send_byte(TERMINATOR);
  endtask

  // Waits until every expected result has arrived and the block has had time to go quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_length(input int fl);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= {REG_FRAME_LENGTH, 2'b00};
    cfg_pwdata <= fl;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    fl_shadow = fl & 6'h3F;
  endtask

  task automatic test_reset_length();
    logic [BYTE_W-1:0] words [8] = '{8'h00, 8'hFF, 8'h20, 8'h1F, 8'h7E, 8'h0B, 8'h09, 8'h80};
    foreach (words[i]) send_byte(words[i]);
    // The offset words XOR to 0xFC, so the checksum byte is 0x1C.
    send_byte(8'h1C);
    send_byte(TERMINATOR);
    settle();
  endtask

  task automatic test_frame_errors();
    write_frame_length(1);
    send_text("");
    send_text("A");
    send_text("ABC");
    send_text("AB");
    send_text("AA");
    settle();
  endtask

  task automatic test_illegal_lengths();
    write_frame_length(0);
    send_text("");
    send_text("A");
    settle();
    write_frame_length(63);
    send_text("");
    settle();
  endtask

  task automatic test_length_change_mid_frame();
    write_frame_length(4);
    send_byte("A");
    send_byte("B");
    settle();
    // With two words already held, the next byte becomes the checksum.
    write_frame_length(2);
    send_byte("#");
    send_byte(TERMINATOR);
    settle();
  endtask

  task automatic test_random_frames();
    int fl_plan [10] = '{3, 32, 1, 0, 16, 63, 5, 31, 2, 33};
    int start;
    int pick;
    int cap;
    foreach (fl_plan[p]) begin
      write_frame_length(fl_plan[p]);
      start = sent_count;
      cap = (fl_shadow > MAX_WORDS) ? MAX_WORDS + 3 : fl_shadow;
      while (sent_count - start < 6) begin
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
          send_frame(cap, CHK_RIGHT);
        end else if (pick < 15) begin
          send_frame(cap, CHK_WRONG);
        end else if (pick < 17) begin
          send_frame((cap == 0) ? 0 : $urandom_range(0, cap - 1), CHK_RIGHT);
        end else if (pick < 19) begin
          send_frame(cap + $urandom_range(1, (cap == MAX_WORDS) ? 6 : 3),
                     $urandom_range(0, 1) ? CHK_RIGHT : CHK_WRONG);
        end else begin
          send_frame($urandom_range(0, 5), CHK_NONE);
        end
      end
      settle();
    end
  endtask

  task automatic test_output_hold_off();
    write_frame_length(MAX_WORDS);
    hold_len = 400;
    hold_req = 1'b1;
    repeat (2) send_frame(MAX_WORDS, CHK_RIGHT);
    settle();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_frame_errors();
    test_illegal_lengths();
    test_length_change_mid_frame();
    test_random_frames();
    test_output_hold_off();

    if (err_count == 0 && frame_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
